// ----- src/ordered_list_append_delete_top_defines.svh -----
// Assertion macros used by the checker file.
`ifndef ORDERED_LIST_APPEND_DELETE_TOP_DEFINES_SVH
`define ORDERED_LIST_APPEND_DELETE_TOP_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define OLAD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("olad check failed");

// Next-cycle implication, disabled in reset.
`define OLAD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("olad check failed");

// Next-cycle implication, also checked in reset.
`define OLAD_ASSERT_NXT_ANY(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("olad check failed");

`endif

// ----- src/olad_pkg.sv -----
// Shared types and constants for the ordered list block.
package olad_pkg;

  localparam int unsigned LIST_DEPTH_DEF = 16;
  localparam int unsigned VAL_W          = 32;

  typedef enum logic [1:0] {
    KIND_APPEND = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_DUMP   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    RES_OK        = 2'd0,
    RES_EMPTY     = 2'd1,
    RES_NOT_FOUND = 2'd2,
    RES_FULL      = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_APPEND,
    ST_DELETE,
    ST_SCAN,
    ST_FINISH,
    ST_DUMP
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic    capture;
    logic    append_wr;
    logic    dec;
    logic    scan;
    logic    dump;
    logic    post;
    status_t code;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic cnt_zero;
    logic cnt_full;
    logic found;
    logic pass_done;
    logic slot_free;
  } stat_t;

endpackage

// ----- src/olad_if.sv -----
// Request and result channel interfaces.
interface olad_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [31:0] value;
  modport source (output valid, kind, value, input ready);
  modport sink   (input valid, kind, value, output ready);
endinterface

interface olad_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] item;
  logic               last;
  modport source (output valid, status, item, last, input ready);
  modport sink   (input valid, status, item, last, output ready);
endinterface

// ----- src/ordered_list_append_delete_top.sv -----
// Top level of the ordered list block: append, delete first match, dump.
//
//   channel | dir | payload               | note
//   in_ch   | in  | kind, value           | request, one at a time
//   out_ch  | out | status, item, last    | one result, count results on dump, none for unused kind
//
// A request runs to its end before the next one is taken. A delete has the single
// RAM read port visit each stored entry once and shift the later ones up a slot
// behind the match; a dump gives one result per cycle while the sink is ready,
// behind the registered RAM read.
// Reset: synchronous, active low, empties the list; the RAM is not cleared.
// Stalls: a held result stops a dump in place; a new request is taken while
// the last result of the previous one still waits in the output register.
module ordered_list_append_delete_top import olad_pkg::*; #(
  parameter int unsigned LIST_DEPTH = LIST_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  olad_in_if.sink    in_ch,
  olad_out_if.source out_ch
);

  cmd_t  cmd;
  stat_t stat;

  // Sequences each request and decides when a result is posted.
  olad_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_kind  (in_ch.kind),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Holds the entries, the count and the result register.
  olad_dp #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_value   (in_ch.value),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .out_status (out_ch.status),
    .out_item   (out_ch.item),
    .out_last   (out_ch.last)
  );

endmodule

// ----- src/olad_ram.sv -----
// Generic simple dual-port RAM, registered read with read enable.
module olad_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- src/olad_ctrl.sv -----
// Controller state machine for the ordered list.
module olad_ctrl import olad_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  input  logic  [1:0] in_kind,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (kind_t'(in_kind))
            KIND_APPEND: state_nxt = ST_APPEND;
            KIND_DELETE: state_nxt = ST_DELETE;
            KIND_DUMP:   state_nxt = ST_DUMP;
            default:     state_nxt = ST_IDLE;  // no such operation
          endcase
        end
      end
      ST_APPEND: begin
        if (stat.slot_free) state_nxt = ST_IDLE;
      end
      ST_DELETE: begin
        if (!stat.cnt_zero)      state_nxt = ST_SCAN;
        else if (stat.slot_free) state_nxt = ST_IDLE;
      end
      ST_SCAN: begin
        if (stat.pass_done) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (stat.slot_free) state_nxt = ST_IDLE;
      end
      ST_DUMP: begin
        if (stat.cnt_zero ? stat.slot_free : stat.pass_done) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.code = RES_OK;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_APPEND: begin
        cmd.post      = stat.slot_free;
        cmd.append_wr = stat.slot_free && !stat.cnt_full;
        cmd.code      = stat.cnt_full ? RES_FULL : RES_OK;
      end
      ST_DELETE: begin
        cmd.post = stat.cnt_zero && stat.slot_free;
        cmd.code = RES_EMPTY;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
      end
      ST_FINISH: begin
        cmd.post = stat.slot_free;
        cmd.dec  = stat.slot_free && stat.found;
        cmd.code = stat.found ? RES_OK : RES_NOT_FOUND;
      end
      ST_DUMP: begin
        cmd.dump = !stat.cnt_zero;
        cmd.post = stat.cnt_zero && stat.slot_free;
        cmd.code = RES_EMPTY;
      end
      default: begin
        cmd.code = RES_OK;
      end
    endcase
  end

endmodule

// ----- src/olad_dp.sv -----
// Datapath: entry RAM, count, read pointer, compare and result register.
module olad_dp import olad_pkg::*; #(
  parameter int unsigned LIST_DEPTH = LIST_DEPTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cmd_t                    cmd,
  output stat_t                   stat,
  input  logic signed [VAL_W-1:0] in_value,
  input  logic                    out_ready,
  output logic                    out_valid,
  output logic [1:0]              out_status,
  output logic signed [VAL_W-1:0] out_item,
  output logic                    out_last
);

  localparam int unsigned AW = $clog2(LIST_DEPTH);
  localparam int unsigned CW = $clog2(LIST_DEPTH + 1);

  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [CW-1:0]    rd_addr_r, rd_addr_nxt;
  logic [AW-1:0]    tag_r, tag_nxt;
  logic             dvalid_r, dvalid_nxt;
  logic             found_r, found_nxt;
  logic [VAL_W-1:0] val_r, val_nxt;

  logic             out_valid_r, out_valid_nxt;
  status_t          out_status_r, out_status_nxt;
  logic [VAL_W-1:0] out_item_r, out_item_nxt;
  logic             out_last_r, out_last_nxt;

  logic             slot_free, consume, issue, tag_last, hit;
  logic             we;
  logic [AW-1:0]    waddr;
  logic [VAL_W-1:0] wdata, rdata;

  assign slot_free = !out_valid_r || out_ready;
  assign consume   = dvalid_r && (cmd.scan || (cmd.dump && slot_free));
  assign issue     = (cmd.scan || cmd.dump) && (rd_addr_r < cnt_r) && (!dvalid_r || consume);
  assign tag_last  = (CW'(tag_r) == (cnt_r - CW'(1)));
  assign hit       = (rdata == val_r);

  // Append writes at the tail; a delete pass moves each later entry up one slot.
  always_comb begin
    we    = 1'b0;
    waddr = cnt_r[AW-1:0];
    wdata = val_r;
    if (cmd.append_wr) begin
      we = 1'b1;
    end else if (cmd.scan && consume && found_r) begin
      we    = 1'b1;
      waddr = tag_r - AW'(1);
      wdata = rdata;
    end
  end

  olad_ram #(
    .WIDTH (VAL_W),
    .DEPTH (LIST_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (issue),
    .raddr (rd_addr_r[AW-1:0]),
    .rdata (rdata)
  );

  always_comb begin
    cnt_nxt     = cnt_r;
    rd_addr_nxt = rd_addr_r;
    tag_nxt     = tag_r;
    dvalid_nxt  = dvalid_r;
    found_nxt   = found_r;
    val_nxt     = val_r;
    if (cmd.capture) begin
      val_nxt     = in_value;
      rd_addr_nxt = '0;
      dvalid_nxt  = 1'b0;
      found_nxt   = 1'b0;
    end else begin
      if (issue) begin
        rd_addr_nxt = rd_addr_r + CW'(1);
        tag_nxt     = rd_addr_r[AW-1:0];
        dvalid_nxt  = 1'b1;
      end else if (consume) begin
        dvalid_nxt  = 1'b0;
      end
      if (cmd.scan && consume && !found_r && hit) begin
        found_nxt = 1'b1;
      end
    end
    if (cmd.append_wr) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (cmd.dec) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_item_nxt   = out_item_r;
    out_last_nxt   = out_last_r;
    if (cmd.post) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = cmd.code;
      out_item_nxt   = '0;
      out_last_nxt   = 1'b1;
    end else if (cmd.dump && consume) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = RES_OK;
      out_item_nxt   = rdata;
      out_last_nxt   = tag_last;
    end else if (out_ready) begin
      out_valid_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      rd_addr_r   <= '0;
      dvalid_r    <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      rd_addr_r   <= rd_addr_nxt;
      dvalid_r    <= dvalid_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tag_r        <= tag_nxt;
    val_r        <= val_nxt;
    out_status_r <= out_status_nxt;
    out_item_r   <= out_item_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign stat.cnt_zero  = (cnt_r == '0);
  assign stat.cnt_full  = (cnt_r == CW'(LIST_DEPTH));
  assign stat.found     = found_r;
  assign stat.pass_done = consume && tag_last;
  assign stat.slot_free = slot_free;

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_item   = out_item_r;
  assign out_last   = out_last_r;

endmodule

// ----- src/olad_chk.sv -----
// Port-level checker for the ordered list block, with its bind.
`include "ordered_list_append_delete_top_defines.svh"

module olad_chk import olad_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic [1:0]         in_kind,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         out_status,
  input logic signed [31:0] out_item,
  input logic               out_last
);

  logic [34:0] out_bus;
  assign out_bus = {out_status, out_item, out_last};

  `OLAD_ASSERT_NXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_bus))
  `OLAD_ASSERT_IMP(a_err_last, clk, rst_n, out_valid && (out_status != RES_OK), out_last && (out_item == '0))
  `OLAD_ASSERT_NXT(a_busy, clk, rst_n, in_valid && in_ready && (in_kind <= KIND_DUMP), !in_ready)
  `OLAD_ASSERT_NXT_ANY(a_rst, clk, !rst_n, !out_valid)

endmodule

bind ordered_list_append_delete_top olad_chk u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_kind    (in_ch.kind),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status),
  .out_item   (out_ch.item),
  .out_last   (out_ch.last)
);

// ----- dv/tb_ordered_list_append_delete_top.sv -----
// Self-checking testbench for the ordered list block: directed and random requests.
module tb_ordered_list_append_delete_top import olad_pkg::*; ();

  localparam int unsigned LIST_CAP = 16;
  // Kind code with no operation behind it; the block must swallow it silently.
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  // Cycles without any handshake before the run is declared hung.
  localparam int unsigned HANG_LIMIT = 4000;
  // Settle time after the last expected result (covers a full-list scan).
  localparam int unsigned DRAIN_CYCLES = 60;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned RANDOM_REQUESTS = 350;

  typedef struct {
    status_t            status;
    logic signed [31:0] item;
    logic               last;
  } list_result_t;

  logic clk = 1'b0;
  logic rst_n;

  olad_in_if  in_ch ();
  olad_out_if out_ch ();

  ordered_list_append_delete_top #(.LIST_DEPTH(LIST_CAP)) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Mirror of the list contents, head at index 0, and results still owed.
  logic signed [31:0] list_mirror[$];
  list_result_t       pending_results[$];

  int unsigned fail_count = 0;
  int unsigned report_count = 0;
  bit          idle_enabled = 1'b1;

  // Result sink: ready is a plain register so nothing races with the block.
  logic sink_ready = 1'b0;
  int   stall_left = 0;
  assign out_ch.ready = sink_ready;

  // Mostly back-to-back, some short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_enabled || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Work out what one accepted request must produce and update the mirror.
  function automatic void apply_list_op(logic [1:0] kind, logic signed [31:0] value);
    list_result_t res;
    int           hit;
    res.item = '0;
    res.last = 1'b1;
    case (kind)
      KIND_APPEND: begin
        if (list_mirror.size() >= LIST_CAP) begin
          res.status = RES_FULL;
        end else begin
          list_mirror.push_back(value);
          res.status = RES_OK;
        end
        pending_results.push_back(res);
      end
      KIND_DELETE: begin
        hit = -1;
        foreach (list_mirror[i]) begin
          if (hit < 0 && list_mirror[i] == value) hit = i;
        end
        if (list_mirror.size() == 0) begin
          res.status = RES_EMPTY;
        end else if (hit < 0) begin
          res.status = RES_NOT_FOUND;
        end else begin
          list_mirror.delete(hit);
          res.status = RES_OK;
        end
        pending_results.push_back(res);
      end
      KIND_DUMP: begin
        if (list_mirror.size() == 0) begin
          res.status = RES_EMPTY;
          pending_results.push_back(res);
        end else begin
          foreach (list_mirror[i]) begin
            res.status = RES_OK;
            res.item   = list_mirror[i];
            res.last   = (i == list_mirror.size() - 1);
            pending_results.push_back(res);
          end
        end
      end
      default: ; // unused kind: no state change, no result
    endcase
  endfunction

  function automatic void note_failure(string what, list_result_t want);
    fail_count++;
    if (report_count < MAX_REPORTS) begin
      report_count++;
      $display("MISMATCH %s: expected status=%0d item=%0d last=%0d, got status=%0d item=%0d last=%0d",
               what, want.status, want.item, want.last,
               out_ch.status, out_ch.item, out_ch.last);
    end
  endfunction

  // Predict on each accepted request, compare each accepted result in order.
  always @(posedge clk) begin
    list_result_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) apply_list_op(in_ch.kind, in_ch.value);
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          want.status = RES_OK;
          want.item   = '0;
          want.last   = 1'b0;
          note_failure("result with nothing pending", want);
        end else begin
          want = pending_results.pop_front();
          if (out_ch.status !== want.status || out_ch.item !== want.item ||
              out_ch.last !== want.last)
            note_failure("wrong result", want);
        end
      end
    end
  end

  // Random stalls on the result side; a stall is drawn in about one ready cycle in four.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      sink_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      sink_ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left <= pick_gap();
    end
  end

  // Watchdog: any handshake on either side counts as progress.
  int unsigned quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= HANG_LIMIT) begin
      $display("ordered_list_append_delete_top verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one request after a random gap and hold it until taken.
  // Valid stays high across back-to-back requests (one NBA per edge).
  task automatic send_request(logic [1:0] kind, logic signed [31:0] value);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind  <= kind;
    in_ch.value <= value;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Empty-list corners: dump and delete both report empty; unused kind is dropped.
  task automatic test_empty_list();
    send_request(KIND_DUMP, 32'sd0);
    send_request(KIND_DELETE, 32'sd0);
    send_request(KIND_UNUSED, 32'sh7FFF_FFFF);
  endtask

  // Fill with extremes and duplicates, overflow once, then list it all.
  task automatic test_fill_and_overflow();
    logic signed [31:0] fill_values[16];
    fill_values = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd0, -32'sd1,
                    32'sd5, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sd5,
                    -32'sd7, 32'sd5, 32'sd1, 32'sh0001_0000,
                    32'sd2, 32'sd3, 32'sd4, 32'sh8000_0001};
    foreach (fill_values[i]) send_request(KIND_APPEND, fill_values[i]);
    send_request(KIND_APPEND, 32'sd9);   // list full: refused
    send_request(KIND_DUMP, 32'sd0);
  endtask

  // Delete at the head, first of several duplicates, the tail and an absent value, then an unused kind and a dump.
  task automatic test_delete_positions();
    send_request(KIND_DELETE, 32'sh8000_0000);
    send_request(KIND_DELETE, 32'sd5);
    send_request(KIND_DELETE, 32'sh8000_0001);
    send_request(KIND_DELETE, 32'sd42);
    send_request(KIND_UNUSED, 32'sh1234_5678);
    send_request(KIND_DUMP, 32'sd0);
  endtask

  // Random mix; the append share shifts so the list swings between empty and full.
  task automatic test_random_traffic(int unsigned n);
    int unsigned        append_pct;
    int unsigned        r;
    logic [1:0]         kind;
    logic signed [31:0] value;
    append_pct = 50;
    for (int unsigned k = 0; k < n; k++) begin
      if (k % 40 == 0) begin
        case ($urandom_range(0, 2))
          0:       append_pct = 25;
          1:       append_pct = 50;
          default: append_pct = 80;
        endcase
        idle_enabled = ($urandom_range(0, 3) != 0);
      end
      r = $urandom_range(0, 99);
      // small pool makes duplicates likely; full-range values exercise every bit
      value = $urandom_range(0, 1) ? 32'($urandom_range(0, 8)) - 32'sd4 : $urandom;
      if (r < 3) begin
        kind = KIND_UNUSED;
      end else if (r < 13) begin
        kind = KIND_DUMP;
      end else if (r < 13 + append_pct * 87 / 100) begin
        kind = KIND_APPEND;
      end else begin
        kind = KIND_DELETE;
        // mostly delete something that is actually stored
        if (list_mirror.size() != 0 && $urandom_range(0, 3) != 0)
          value = list_mirror[$urandom_range(0, list_mirror.size() - 1)];
      end
      send_request(kind, value);
    end
    idle_enabled = 1'b1;
  endtask

  initial begin
    in_ch.valid <= 1'b0;
    in_ch.kind  <= KIND_APPEND;
    in_ch.value <= '0;
    rst_n       <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_list();
    test_fill_and_overflow();
    test_delete_positions();
    test_random_traffic(RANDOM_REQUESTS);
    in_ch.valid <= 1'b0;

    // Drain: every owed result, then a quiet window for stray outputs.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      fail_count++;
      $display("%0d expected results never arrived", pending_results.size());
    end

    if (fail_count == 0) begin
      $display("ordered_list_append_delete_top verification clean");
    end else begin
      $display("ordered_list_append_delete_top verification failed");
    end
    $finish;
  end

endmodule
